// File: rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// shared constants, register map, types and helpers of the pattern generator
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = 13;
    localparam int TILE_W    = 11;
    localparam int COORD_W   = 12;
    localparam int MAX_DIM   = 4096;
    localparam int MAX_TILES = 1024;
    localparam int PROD_W    = 22;
    localparam int POS_W     = PROD_W + FRAC_BITS;
    localparam int RQ_W      = 24;
    localparam int MOD_W     = PROD_W + 1;
    localparam int BDIV_W    = POS_W + FRAC_BITS;
    localparam int COLOR_W   = 32;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int REGIDX_W  = 3;

    localparam int COORD_LAT = 1 + POS_W;
    localparam int BRICK_LAT = 1 + MOD_W + BDIV_W;
    localparam int SHADE_LAT = 3;

    localparam logic [2:0] MODE_CHECKER = 3'd0;
    localparam logic [2:0] MODE_GRID    = 3'd1;
    localparam logic [2:0] MODE_BRICK   = 3'd2;
    localparam logic [2:0] MODE_STRIPES = 3'd3;
    localparam logic [2:0] MODE_DOTS    = 3'd4;

    localparam logic [REGIDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_WIDTH   = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_HEIGHT  = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_TILES_X = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_TILES_Y = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_LINE    = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_BRICK   = 3'd6;
    localparam logic [REGIDX_W-1:0] REG_COLOR   = 3'd7;

    localparam logic [15:0] HALF_CELL = 16'h8000;
    localparam logic [38:0] DOT_LIMIT = 39'(9) << (2 * FRAC_BITS);

    typedef struct packed {
        logic [2:0]         mode;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [TILE_W-1:0]  tx;
        logic [TILE_W-1:0]  ty;
        logic [15:0]        lw;
        logic [RQ_W-1:0]    rq;
        logic [15:0]        off;
        logic [COLOR_W-1:0] prim_color;
        logic [COLOR_W-1:0] sec_color;
    } ppg_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } ppg_pos_t;

    typedef struct packed {
        logic        cx0;
        logic        cy0;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] bx;
    } ppg_cell_t;

    function automatic logic in_band(logic [15:0] pos, logic [15:0] lw);
        logic [16:0] sum;
        sum = {1'b0, pos} + {1'b0, lw};
        return (pos > lw) && (sum < 17'h10000);
    endfunction

endpackage

// File: rtl/ppg_regs.sv
// ----------------------------------------------------------------------------
// ppg_regs
// configuration register file with apb access and clamped settings
// ----------------------------------------------------------------------------
module ppg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppg_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppg_pkg::DATA_W-1:0]   pwdata,
    output logic [ppg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output ppg_pkg::ppg_cfg_t            cfg
);

    logic [2:0]  mode_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [10:0] tiles_x_reg;
    logic [10:0] tiles_y_reg;
    logic [15:0] line_reg;
    logic [31:0] brick_reg;
    logic [63:0] color_reg;

    logic                              wr_en;
    logic [ppg_pkg::REGIDX_W-1:0]      wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[ppg_pkg::ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 3'd0;
            width_reg   <= 13'd1024;
            height_reg  <= 13'd1024;
            tiles_x_reg <= 11'd8;
            tiles_y_reg <= 11'd8;
            line_reg    <= 16'd1311;
            brick_reg   <= 32'h8000_0200;
            color_reg   <= 64'hFF00_0000_FFFF_FFFF;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                ppg_pkg::REG_MODE:    mode_reg    <= pwdata[2:0];
                ppg_pkg::REG_WIDTH:   width_reg   <= pwdata[12:0];
                ppg_pkg::REG_HEIGHT:  height_reg  <= pwdata[12:0];
                ppg_pkg::REG_TILES_X: tiles_x_reg <= pwdata[10:0];
                ppg_pkg::REG_TILES_Y: tiles_y_reg <= pwdata[10:0];
                ppg_pkg::REG_LINE:    line_reg    <= pwdata[15:0];
                ppg_pkg::REG_BRICK:   brick_reg   <= pwdata[31:0];
                ppg_pkg::REG_COLOR:   color_reg   <= pwdata;
                default:              mode_reg    <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ppg_pkg::ADDR_W-1:3])
            ppg_pkg::REG_MODE:    prdata = {61'd0, mode_reg};
            ppg_pkg::REG_WIDTH:   prdata = {51'd0, width_reg};
            ppg_pkg::REG_HEIGHT:  prdata = {51'd0, height_reg};
            ppg_pkg::REG_TILES_X: prdata = {53'd0, tiles_x_reg};
            ppg_pkg::REG_TILES_Y: prdata = {53'd0, tiles_y_reg};
            ppg_pkg::REG_LINE:    prdata = {48'd0, line_reg};
            ppg_pkg::REG_BRICK:   prdata = {32'd0, brick_reg};
            ppg_pkg::REG_COLOR:   prdata = color_reg;
            default:              prdata = '0;
        endcase
    end

    function automatic logic [12:0] clamp_dim(logic [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        else if (v > 13'(ppg_pkg::MAX_DIM))
            return 13'(ppg_pkg::MAX_DIM);
        else
            return v;
    endfunction

    function automatic logic [10:0] clamp_tiles(logic [10:0] v);
        if (v == 11'd0)
            return 11'd1;
        else if (v > 11'(ppg_pkg::MAX_TILES))
            return 11'(ppg_pkg::MAX_TILES);
        else
            return v;
    endfunction

    always_comb
    begin
        cfg.mode       = mode_reg;
        cfg.w          = clamp_dim(width_reg);
        cfg.h          = clamp_dim(height_reg);
        cfg.tx         = clamp_tiles(tiles_x_reg);
        cfg.ty         = clamp_tiles(tiles_y_reg);
        cfg.lw         = line_reg;
        cfg.rq         = {brick_reg[15:0], 8'd0};
        cfg.off        = brick_reg[31:16];
        cfg.prim_color = color_reg[31:0];
        cfg.sec_color  = color_reg[63:32];
    end

    a_color_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_idx == ppg_pkg::REG_COLOR) |=> cfg.prim_color == $past(pwdata[31:0]))
        else $error("primary color not taken from write");

    a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_idx == ppg_pkg::REG_WIDTH && pwdata[12:0] == 13'd0) |=> cfg.w == 13'd1)
        else $error("zero width not clamped");

    a_tiles_max: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_idx == ppg_pkg::REG_TILES_X && pwdata[10:0] > 11'(ppg_pkg::MAX_TILES))
        |=> cfg.tx == 11'(ppg_pkg::MAX_TILES))
        else $error("tile count not clamped");

endmodule

// File: rtl/ppg_coord.sv
// ----------------------------------------------------------------------------
// ppg_coord
// scales the pixel by the tile count and divides by the image size,
// one quotient bit per stage, giving cell index and in-cell fraction
// ----------------------------------------------------------------------------
module ppg_coord
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  ppg_pkg::ppg_cfg_t              cfg,
    input  logic                           in_valid,
    input  logic [ppg_pkg::COORD_W-1:0]    x,
    input  logic [ppg_pkg::COORD_W-1:0]    y,
    output logic                           out_valid,
    output ppg_pkg::ppg_pos_t              out_pos
);

    typedef struct packed {
        logic [ppg_pkg::DIM_W-1:0] r;
        logic [ppg_pkg::POS_W-1:0] n;
    } div_t;

    logic                        vld_reg [ppg_pkg::COORD_LAT];
    logic [ppg_pkg::PROD_W-1:0]  ux_reg;
    logic [ppg_pkg::PROD_W-1:0]  uy_reg;
    div_t                        dvx_reg [ppg_pkg::POS_W];
    div_t                        dvy_reg [ppg_pkg::POS_W];
    logic [22:0]                 prod_x;
    logic [22:0]                 prod_y;
    div_t                        init_x;
    div_t                        init_y;

    function automatic div_t div_step(div_t d, logic [ppg_pkg::DIM_W-1:0] dv);
        logic [ppg_pkg::DIM_W:0] t;
        div_t                    o;
        t   = {d.r, d.n[ppg_pkg::POS_W-1]};
        o.n = {d.n[ppg_pkg::POS_W-2:0], 1'b0};
        if (t >= {1'b0, dv})
        begin
            o.r    = ppg_pkg::DIM_W'(t - {1'b0, dv});
            o.n[0] = 1'b1;
        end
        else
        begin
            o.r = t[ppg_pkg::DIM_W-1:0];
        end
        return o;
    endfunction

    assign prod_x = x * cfg.tx;
    assign prod_y = y * cfg.ty;
    assign init_x = '{r: '0, n: {ux_reg, 16'd0}};
    assign init_y = '{r: '0, n: {uy_reg, 16'd0}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppg_pkg::COORD_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < ppg_pkg::COORD_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg     <= prod_x[ppg_pkg::PROD_W-1:0];
            uy_reg     <= prod_y[ppg_pkg::PROD_W-1:0];
            dvx_reg[0] <= div_step(init_x, cfg.w);
            dvy_reg[0] <= div_step(init_y, cfg.h);
            for (int i = 1; i < ppg_pkg::POS_W; i++)
            begin
                dvx_reg[i] <= div_step(dvx_reg[i-1], cfg.w);
                dvy_reg[i] <= div_step(dvy_reg[i-1], cfg.h);
            end
        end
    end

    assign out_valid  = vld_reg[ppg_pkg::COORD_LAT-1];
    assign out_pos.px = dvx_reg[ppg_pkg::POS_W-1].n;
    assign out_pos.py = dvy_reg[ppg_pkg::POS_W-1].n;

endmodule

// File: rtl/ppg_brick.sv
// ----------------------------------------------------------------------------
// ppg_brick
// odd row shift with wrap over the tile span, then position within a brick
// by a bit-per-stage division by the brick length
// ----------------------------------------------------------------------------
module ppg_brick
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  ppg_pkg::ppg_cfg_t    cfg,
    input  logic                 in_valid,
    input  ppg_pkg::ppg_pos_t    in_pos,
    output logic                 out_valid,
    output ppg_pkg::ppg_cell_t   out_cell
);

    typedef struct packed {
        logic                       odd;
        logic [ppg_pkg::MOD_W-1:0]  ia;
        logic [15:0]                frac;
        logic [ppg_pkg::POS_W-1:0]  px;
    } shift_t;

    typedef struct packed {
        logic [ppg_pkg::TILE_W-1:0] r;
        logic [ppg_pkg::MOD_W-1:0]  n;
        logic [15:0]                frac;
        logic                       odd;
        logic [ppg_pkg::POS_W-1:0]  px;
    } mod_t;

    typedef struct packed {
        logic [ppg_pkg::RQ_W-1:0]   r;
        logic [ppg_pkg::BDIV_W-1:0] n;
    } bdiv_t;

    typedef struct packed {
        logic        cx0;
        logic        cy0;
        logic [15:0] lx;
        logic [15:0] ly;
    } side_t;

    localparam int SIDE_LAT = ppg_pkg::BRICK_LAT;

    logic   vld_reg  [SIDE_LAT];
    side_t  side_reg [SIDE_LAT];
    shift_t sh_reg;
    mod_t   mod_reg  [ppg_pkg::MOD_W];
    bdiv_t  bdv_reg  [ppg_pkg::BDIV_W];

    logic [ppg_pkg::POS_W:0]   sum;
    shift_t                    sh_next;
    side_t                     side_next;
    mod_t                      mod_init;
    mod_t                      mod_last;
    logic [ppg_pkg::POS_W-1:0] pm;
    bdiv_t                     bdv_init;

    function automatic mod_t mod_step(mod_t d, logic [ppg_pkg::TILE_W-1:0] dv);
        logic [ppg_pkg::TILE_W:0] t;
        mod_t                     o;
        o   = d;
        t   = {d.r, d.n[ppg_pkg::MOD_W-1]};
        o.n = {d.n[ppg_pkg::MOD_W-2:0], 1'b0};
        if (t >= {1'b0, dv})
            o.r = ppg_pkg::TILE_W'(t - {1'b0, dv});
        else
            o.r = t[ppg_pkg::TILE_W-1:0];
        return o;
    endfunction

    function automatic bdiv_t bdiv_step(bdiv_t d, logic [ppg_pkg::RQ_W-1:0] dv);
        logic [ppg_pkg::RQ_W:0] t;
        bdiv_t                  o;
        t   = {d.r, d.n[ppg_pkg::BDIV_W-1]};
        o.n = {d.n[ppg_pkg::BDIV_W-2:0], 1'b0};
        if (t >= {1'b0, dv})
        begin
            o.r    = ppg_pkg::RQ_W'(t - {1'b0, dv});
            o.n[0] = 1'b1;
        end
        else
        begin
            o.r = t[ppg_pkg::RQ_W-1:0];
        end
        return o;
    endfunction

    always_comb
    begin
        sum            = {1'b0, in_pos.px} + {23'd0, cfg.off};
        sh_next.odd    = in_pos.py[ppg_pkg::FRAC_BITS];
        sh_next.ia     = sum[ppg_pkg::POS_W:ppg_pkg::FRAC_BITS];
        sh_next.frac   = sum[15:0];
        sh_next.px     = in_pos.px;
        side_next.cx0  = in_pos.px[ppg_pkg::FRAC_BITS];
        side_next.cy0  = in_pos.py[ppg_pkg::FRAC_BITS];
        side_next.lx   = in_pos.px[15:0];
        side_next.ly   = in_pos.py[15:0];
        mod_init.r     = '0;
        mod_init.n     = sh_reg.ia;
        mod_init.frac  = sh_reg.frac;
        mod_init.odd   = sh_reg.odd;
        mod_init.px    = sh_reg.px;
        mod_last       = mod_reg[ppg_pkg::MOD_W-1];
        pm             = mod_last.odd ? {11'd0, mod_last.r, mod_last.frac} : mod_last.px;
        bdv_init.r     = '0;
        bdv_init.n     = {pm, 16'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < SIDE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SIDE_LAT; i++)
                side_reg[i] <= side_reg[i-1];
            sh_reg     <= sh_next;
            mod_reg[0] <= mod_step(mod_init, cfg.tx);
            for (int i = 1; i < ppg_pkg::MOD_W; i++)
                mod_reg[i] <= mod_step(mod_reg[i-1], cfg.tx);
            bdv_reg[0] <= bdiv_step(bdv_init, cfg.rq);
            for (int i = 1; i < ppg_pkg::BDIV_W; i++)
                bdv_reg[i] <= bdiv_step(bdv_reg[i-1], cfg.rq);
        end
    end

    assign out_valid    = vld_reg[SIDE_LAT-1];
    assign out_cell.cx0 = side_reg[SIDE_LAT-1].cx0;
    assign out_cell.cy0 = side_reg[SIDE_LAT-1].cy0;
    assign out_cell.lx  = side_reg[SIDE_LAT-1].lx;
    assign out_cell.ly  = side_reg[SIDE_LAT-1].ly;
    assign out_cell.bx  = bdv_reg[ppg_pkg::BDIV_W-1].n[15:0];

endmodule

// File: rtl/ppg_shade.sv
// ----------------------------------------------------------------------------
// ppg_shade
// pattern tests, dot distance squares and compare, color select into the
// output register
// ----------------------------------------------------------------------------
module ppg_shade
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  ppg_pkg::ppg_cfg_t             cfg,
    input  logic                          in_valid,
    input  ppg_pkg::ppg_cell_t            in_cell,
    output logic                          out_valid,
    output logic [ppg_pkg::COLOR_W-1:0]   out_color,
    output logic                          out_prim
);

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic [15:0] dx_reg;
    logic [15:0] dy_reg;
    logic        nd_prim_reg;
    logic        dots_reg;
    logic [31:0] sqx_reg;
    logic [31:0] sqy_reg;
    logic        nd_prim2_reg;
    logic        dots2_reg;
    logic [ppg_pkg::COLOR_W-1:0] color_reg;
    logic        prim_reg;

    logic [15:0] dx_next;
    logic [15:0] dy_next;
    logic        nd_prim_next;
    logic        grid_x;
    logic        grid_y;
    logic        brick_x;
    logic [31:0] d2;
    logic [38:0] d100;
    logic        prim_next;

    always_comb
    begin
        dx_next = (in_cell.lx >= ppg_pkg::HALF_CELL) ? in_cell.lx - ppg_pkg::HALF_CELL
                                                     : ppg_pkg::HALF_CELL - in_cell.lx;
        dy_next = (in_cell.ly >= ppg_pkg::HALF_CELL) ? in_cell.ly - ppg_pkg::HALF_CELL
                                                     : ppg_pkg::HALF_CELL - in_cell.ly;
        grid_x  = ppg_pkg::in_band(in_cell.lx, cfg.lw);
        grid_y  = ppg_pkg::in_band(in_cell.ly, cfg.lw);
        brick_x = ppg_pkg::in_band(in_cell.bx, cfg.lw);
        unique case (cfg.mode)
            ppg_pkg::MODE_CHECKER: nd_prim_next = !(in_cell.cx0 ^ in_cell.cy0);
            ppg_pkg::MODE_GRID:    nd_prim_next = grid_x && grid_y;
            ppg_pkg::MODE_BRICK:   nd_prim_next = (cfg.rq != '0) && brick_x && grid_y;
            ppg_pkg::MODE_STRIPES: nd_prim_next = !in_cell.cx0;
            default:               nd_prim_next = 1'b1;
        endcase
    end

    always_comb
    begin
        d2        = sqx_reg + sqy_reg;
        d100      = (39'(d2) << 6) + (39'(d2) << 5) + (39'(d2) << 2);
        prim_next = dots2_reg ? (d100 < ppg_pkg::DOT_LIMIT) : nd_prim2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            nd_prim_reg  <= nd_prim_next;
            dots_reg     <= (cfg.mode == ppg_pkg::MODE_DOTS);
            sqx_reg      <= dx_reg * dx_reg;
            sqy_reg      <= dy_reg * dy_reg;
            nd_prim2_reg <= nd_prim_reg;
            dots2_reg    <= dots_reg;
            prim_reg     <= prim_next;
            color_reg    <= prim_next ? cfg.prim_color : cfg.sec_color;
        end
    end

    assign out_valid = v3_reg;
    assign out_color = color_reg;
    assign out_prim  = prim_reg;

endmodule

// File: rtl/procedural_pattern_pixel_gen_core.sv
// ----------------------------------------------------------------------------
// procedural_pattern_pixel_gen_core
// pixel coordinate in, bgra color of the configured pattern out
//
//   channel   dir  payload
//   s_axis    in   tdata[11:0] pixel_x, tdata[23:12] pixel_y
//   m_axis    out  tdata blue, green, red, alpha; tuser took_primary
//   apb       in   eight 64-bit registers at 8-byte spacing
//
// one item per clock while the output is not stalled: multiply, 38 divide
// stages for the cell position, 78 stages for odd row wrap and brick division,
// 3 shading stages; the divider depth sets the latency
// reset clears the valid bits only, no clearing pass
// a stalled output freezes the whole pipeline, s_tready follows
// ----------------------------------------------------------------------------
module procedural_pattern_pixel_gen_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // pixel_x, pixel_y
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // blue, green, red, alpha
    output logic                         m_tuser,   // took_primary
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppg_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppg_pkg::DATA_W-1:0]   pwdata,
    output logic [ppg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    ppg_pkg::ppg_cfg_t  cfg;
    ppg_pkg::ppg_pos_t  pos;
    ppg_pkg::ppg_cell_t cell_data;
    logic               adv;
    logic               pos_valid;
    logic               cell_valid;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    ppg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppg_coord u_coord
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .x         (s_tdata[11:0]),
        .y         (s_tdata[23:12]),
        .out_valid (pos_valid),
        .out_pos   (pos)
    );

    ppg_brick u_brick
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (pos_valid),
        .in_pos    (pos),
        .out_valid (cell_valid),
        .out_cell  (cell_data)
    );

    ppg_shade u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (cell_valid),
        .in_cell   (cell_data),
        .out_valid (m_tvalid),
        .out_color (m_tdata),
        .out_prim  (m_tuser)
    );

endmodule
